// ----- hdl/bdes_pkg.sv -----
// ----------------------------------------------------------------------------
// bdes_pkg
// Shared types and constants of the box distance estimate step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bdes_pkg;

    localparam int FRAC_BITS = 24;
    localparam int COORD_W   = 32;
    localparam int DIST_W    = 40;
    localparam int DERIV_W   = 48;
    localparam int SIZE_W    = 48;
    localparam int Q_W       = 48;
    localparam int SQ_W      = 2 * Q_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int DIV_W     = DERIV_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int FRONT_STAGES = 9;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_SCALE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PYRAMID_SCALE = 3'd7;

    localparam logic [COORD_W-1:0] ONE_FX = COORD_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [COORD_W-1:0] offset_x;
        logic [COORD_W-1:0] offset_y;
        logic [COORD_W-1:0] offset_z;
        logic [COORD_W-1:0] half_size_x;
        logic [COORD_W-1:0] half_size_y;
        logic [COORD_W-1:0] half_size_z;
        logic [COORD_W-1:0] curve_scale;
        logic [COORD_W-1:0] pyramid_scale;
    } bdes_cfg_t;

    // point (or moved point) and the running values that ride along
    typedef struct packed {
        logic [COORD_W-1:0] mx;
        logic [COORD_W-1:0] my;
        logic [COORD_W-1:0] mz;
        logic [DIST_W-1:0]  run_dist;
        logic [DERIV_W-1:0] deriv;
    } bdes_side_t;

    typedef struct packed {
        logic [COORD_W-1:0] mx;
        logic [COORD_W-1:0] my;
        logic [COORD_W-1:0] mz;
        logic [DIST_W-1:0]  dist_out;
        logic               got_closer;
    } bdes_res_t;

    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
    } bdes_mags_t;

endpackage

`default_nettype wire

// ----- hdl/bdes_front.sv -----
// ----------------------------------------------------------------------------
// bdes_front
// Offset, box shaping and sum of squared outside distances, nine stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bdes_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ce,
    input  wire bdes_pkg::bdes_cfg_t cfg,
    input  wire logic                in_valid,
    input  wire bdes_pkg::bdes_side_t in_side,
    output logic                     out_valid,
    output bdes_pkg::bdes_side_t     out_side,
    output logic [bdes_pkg::SQ_W-1:0] out_sumsq
);
    import bdes_pkg::*;

    localparam int T_W  = 2 * COORD_W - 1 - FRAC_BITS;  // (az*az)>>F
    localparam int HI_W = T_W - COORD_W;
    localparam int CP_W = T_W + COORD_W;
    localparam int CM_W = CP_W - FRAC_BITS;
    localparam int H_W  = Q_W / 2;

    logic       valid_reg [0:FRONT_STAGES-1];
    bdes_side_t side_reg  [0:FRONT_STAGES-1];
    bdes_mags_t mag_reg   [1:4];

    logic                  cs_neg, ps_neg;
    logic [COORD_W-1:0]    cs_mag, ps_mag;

    // stage 1
    bdes_mags_t            mag_next;
    logic [2*COORD_W-1:0]  az2_reg, pmul_reg;
    logic                  pz_neg1_reg, pz_neg2_reg;
    // stage 2
    logic [T_W-1:0]        t_c;
    logic [2*COORD_W-1:0]  cm_lo_reg;
    logic [HI_W+COORD_W-1:0] cm_hi_reg;
    logic [T_W-1:0]        pmag_reg;
    // stage 3
    logic [CP_W-1:0]       cprod_c;
    logic [CM_W-1:0]       cmag_c;
    logic [SIZE_W-1:0]     curve_reg, pyr_reg;
    // stage 4
    logic [SIZE_W-1:0]     sx_reg, sy_reg, sz_reg;
    // stage 5..8
    logic [Q_W-1:0]        q_next [0:2];
    logic [Q_W-1:0]        q_reg  [0:2];
    logic [Q_W-1:0]        pll_reg [0:2];
    logic [Q_W-1:0]        plh_reg [0:2];
    logic [Q_W-1:0]        phh_reg [0:2];
    logic [SQ_W-1:0]       sq_reg  [0:2];
    logic [SQ_W-1:0]       sum_reg;

    assign cs_neg = cfg.curve_scale[COORD_W-1];
    assign ps_neg = cfg.pyramid_scale[COORD_W-1];
    assign cs_mag = cs_neg ? COORD_W'(0) - cfg.curve_scale : cfg.curve_scale;
    assign ps_mag = ps_neg ? COORD_W'(0) - cfg.pyramid_scale : cfg.pyramid_scale;

    always_comb
    begin
        mag_next.ax = side_reg[0].mx[COORD_W-1] ? COORD_W'(0) - side_reg[0].mx
                                                : side_reg[0].mx;
        mag_next.ay = side_reg[0].my[COORD_W-1] ? COORD_W'(0) - side_reg[0].my
                                                : side_reg[0].my;
        mag_next.az = side_reg[0].mz[COORD_W-1] ? COORD_W'(0) - side_reg[0].mz
                                                : side_reg[0].mz;
    end

    assign t_c     = az2_reg[FRAC_BITS +: T_W];
    assign cprod_c = {cm_hi_reg, {COORD_W{1'b0}}} + {{HI_W{1'b0}}, cm_lo_reg};
    assign cmag_c  = cprod_c[CP_W-1:FRAC_BITS];

    always_comb
    begin
        logic [SIZE_W:0] dx, dy, dz;
        dx = {{(SIZE_W+1-COORD_W){1'b0}}, mag_reg[4].ax} - {sx_reg[SIZE_W-1], sx_reg};
        dy = {{(SIZE_W+1-COORD_W){1'b0}}, mag_reg[4].ay} - {sy_reg[SIZE_W-1], sy_reg};
        dz = {{(SIZE_W+1-COORD_W){1'b0}}, mag_reg[4].az} - {sz_reg[SIZE_W-1], sz_reg};
        q_next[0] = dx[SIZE_W] ? '0 : dx[Q_W-1:0];
        q_next[1] = dy[SIZE_W] ? '0 : dy[Q_W-1:0];
        q_next[2] = dz[SIZE_W] ? '0 : dz[Q_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FRONT_STAGES; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < FRONT_STAGES; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // stage 0: move the point
            side_reg[0].mx       <= in_side.mx + cfg.offset_x;
            side_reg[0].my       <= in_side.my + cfg.offset_y;
            side_reg[0].mz       <= in_side.mz + cfg.offset_z;
            side_reg[0].run_dist <= in_side.run_dist;
            side_reg[0].deriv    <= in_side.deriv;
            for (int k = 1; k < FRONT_STAGES; k++)
                side_reg[k] <= side_reg[k-1];

            // stage 1: magnitudes, z squared, pyramid product
            mag_reg[1]  <= mag_next;
            az2_reg     <= mag_next.az * mag_next.az;
            pmul_reg    <= mag_next.az * ps_mag;
            pz_neg1_reg <= side_reg[0].mz[COORD_W-1];

            // stage 2: curve product in two parts
            mag_reg[2]  <= mag_reg[1];
            pz_neg2_reg <= pz_neg1_reg;
            cm_lo_reg   <= t_c[COORD_W-1:0] * cs_mag;
            cm_hi_reg   <= t_c[T_W-1:COORD_W] * cs_mag;
            pmag_reg    <= pmul_reg[FRAC_BITS +: T_W];

            // stage 3: signed curve and pyramid terms
            mag_reg[3] <= mag_reg[2];
            curve_reg  <= cs_neg ? SIZE_W'(0) - SIZE_W'(cmag_c) : SIZE_W'(cmag_c);
            pyr_reg    <= (ps_neg != pz_neg2_reg) ? SIZE_W'(0) - SIZE_W'(pmag_reg)
                                                  : SIZE_W'(pmag_reg);

            // stage 4: shaped half sizes
            mag_reg[4] <= mag_reg[3];
            sx_reg <= {{(SIZE_W-COORD_W){cfg.half_size_x[COORD_W-1]}}, cfg.half_size_x}
                      + curve_reg - pyr_reg;
            sy_reg <= {{(SIZE_W-COORD_W){cfg.half_size_y[COORD_W-1]}}, cfg.half_size_y}
                      + curve_reg - pyr_reg;
            sz_reg <= {{(SIZE_W-COORD_W){cfg.half_size_z[COORD_W-1]}}, cfg.half_size_z};

            // stages 5..8: clamp, partial squares, squares, sum
            for (int a = 0; a < 3; a++)
            begin
                q_reg[a]   <= q_next[a];
                pll_reg[a] <= q_reg[a][H_W-1:0] * q_reg[a][H_W-1:0];
                plh_reg[a] <= q_reg[a][Q_W-1:H_W] * q_reg[a][H_W-1:0];
                phh_reg[a] <= q_reg[a][Q_W-1:H_W] * q_reg[a][Q_W-1:H_W];
                sq_reg[a]  <= {phh_reg[a], {Q_W{1'b0}}}
                              + {{(H_W-1){1'b0}}, plh_reg[a], {(H_W+1){1'b0}}}
                              + {{Q_W{1'b0}}, pll_reg[a]};
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign out_valid = valid_reg[FRONT_STAGES-1];
    assign out_side  = side_reg[FRONT_STAGES-1];
    assign out_sumsq = sum_reg;

endmodule

`default_nettype wire

// ----- hdl/bdes_sqrt.sv -----
// ----------------------------------------------------------------------------
// bdes_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bdes_sqrt
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  ce,
    input  wire logic                  in_valid,
    input  wire bdes_pkg::bdes_side_t  in_side,
    input  wire logic [bdes_pkg::SQ_W-1:0] in_rad,
    output logic                       out_valid,
    output bdes_pkg::bdes_side_t       out_side,
    output logic [bdes_pkg::ROOT_W-1:0] out_len
);
    import bdes_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic              valid_reg [0:ROOT_W-1];
    bdes_side_t        side_reg  [0:ROOT_W-1];
    logic [SQ_W-1:0]   rad_reg   [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg  [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic              v_i;
        bdes_side_t        side_i;
        logic [SQ_W-1:0]   rad_i;
        logic [REM_W-1:0]  rem_i;
        logic [ROOT_W-1:0] root_i;
        logic [REM_W+1:0]  rem_ext, trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign v_i    = in_valid;
            assign side_i = in_side;
            assign rad_i  = in_rad;
            assign rem_i  = '0;
            assign root_i = '0;
        end
        else
        begin : g_next
            assign v_i    = valid_reg[k-1];
            assign side_i = side_reg[k-1];
            assign rad_i  = rad_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
        end

        // bring down the next bit pair and try root*4+1
        assign rem_ext = {rem_i, rad_i[SQ_W-1 -: 2]};
        assign trial   = {2'b00, root_i, 2'b01};
        assign take    = rem_ext >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (ce)
                valid_reg[k] <= v_i;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                side_reg[k] <= side_i;
                rad_reg[k]  <= {rad_i[SQ_W-3:0], 2'b00};
                rem_reg[k]  <= take ? REM_W'(rem_ext - trial) : REM_W'(rem_ext);
                root_reg[k] <= {root_i[ROOT_W-2:0], take};
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_len   = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- hdl/bdes_div.sv -----
// ----------------------------------------------------------------------------
// bdes_div
// Pipelined restoring divide of the length by (deriv + 1), then the minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module bdes_div
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   ce,
    input  wire logic                   in_valid,
    input  wire bdes_pkg::bdes_side_t   in_side,
    input  wire logic [bdes_pkg::ROOT_W-1:0] in_len,
    output logic                        out_valid,
    output bdes_pkg::bdes_res_t         out_res
);
    import bdes_pkg::*;

    localparam int SHIFT = DIST_W - FRAC_BITS;    // integer bits of the quotient
    localparam int CMP_W = DIV_W + SHIFT;

    // preparation stage
    logic              pre_valid_reg;
    bdes_side_t        pre_side_reg;
    logic [DIV_W-1:0]  pre_d_reg, pre_rem_reg;
    logic [DIST_W-1:0] pre_nb_reg;
    logic              pre_ovf_reg;

    // quotient bit stages
    logic              valid_reg [0:DIST_W-1];
    bdes_side_t        side_reg  [0:DIST_W-1];
    logic [DIV_W-1:0]  d_reg     [0:DIST_W-1];
    logic [DIV_W-1:0]  rem_reg   [0:DIST_W-1];
    logic [DIST_W-1:0] nb_reg    [0:DIST_W-1];
    logic [DIST_W-1:0] quo_reg   [0:DIST_W-1];
    logic              ovf_reg   [0:DIST_W-1];

    // result stage
    logic              res_valid_reg;
    bdes_res_t         res_reg;

    logic [DIV_W-1:0]  d_c;
    logic [DIST_W-1:0] val_c, dout_c;

    assign d_c = {1'b0, in_side.deriv} + DIV_W'(ONE_FX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (ce)
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pre_side_reg <= in_side;
            pre_d_reg    <= d_c;
            // quotient of 2^DIST_W or more saturates
            pre_ovf_reg  <= {{(CMP_W-ROOT_W){1'b0}}, in_len} >= {d_c, {SHIFT{1'b0}}};
            pre_rem_reg  <= DIV_W'(in_len[ROOT_W-1:SHIFT]);
            pre_nb_reg   <= {in_len[SHIFT-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    for (genvar k = 0; k < DIST_W; k++)
    begin : g_step
        logic              v_i, ovf_i;
        bdes_side_t        side_i;
        logic [DIV_W-1:0]  d_i, rem_i;
        logic [DIST_W-1:0] nb_i, quo_i;
        logic [DIV_W:0]    rem_ext;
        logic              take;

        if (k == 0)
        begin : g_first
            assign v_i    = pre_valid_reg;
            assign side_i = pre_side_reg;
            assign d_i    = pre_d_reg;
            assign rem_i  = pre_rem_reg;
            assign nb_i   = pre_nb_reg;
            assign quo_i  = '0;
            assign ovf_i  = pre_ovf_reg;
        end
        else
        begin : g_next
            assign v_i    = valid_reg[k-1];
            assign side_i = side_reg[k-1];
            assign d_i    = d_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign nb_i   = nb_reg[k-1];
            assign quo_i  = quo_reg[k-1];
            assign ovf_i  = ovf_reg[k-1];
        end

        assign rem_ext = {rem_i, nb_i[DIST_W-1]};
        assign take    = rem_ext >= {1'b0, d_i};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (ce)
                valid_reg[k] <= v_i;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                side_reg[k] <= side_i;
                d_reg[k]    <= d_i;
                ovf_reg[k]  <= ovf_i;
                rem_reg[k]  <= take ? DIV_W'(rem_ext - {1'b0, d_i}) : DIV_W'(rem_ext);
                nb_reg[k]   <= {nb_i[DIST_W-2:0], 1'b0};
                quo_reg[k]  <= {quo_i[DIST_W-2:0], take};
            end
        end
    end

    assign val_c  = ovf_reg[DIST_W-1] ? '1 : quo_reg[DIST_W-1];
    assign dout_c = (val_c < side_reg[DIST_W-1].run_dist) ? val_c
                                                          : side_reg[DIST_W-1].run_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (ce)
            res_valid_reg <= valid_reg[DIST_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            res_reg.mx         <= side_reg[DIST_W-1].mx;
            res_reg.my         <= side_reg[DIST_W-1].my;
            res_reg.mz         <= side_reg[DIST_W-1].mz;
            res_reg.dist_out   <= dout_c;
            res_reg.got_closer <= dout_c != side_reg[DIST_W-1].run_dist;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- hdl/box_distance_estimate_step_unit.sv -----
// an accepted input beat passes 9 front stages, 48 square root stages, 42 divide
//   stages and the output register before it leaves as an output beat
// throughput: one beat per cycle; the pipeline advances as one while the skid
//   register is empty, so input is taken even while an output beat waits
// reset: rst_n clears all valid bits and loads the registers with zero offsets,
//   half sizes of 1.0 and zero curve and pyramid gains
// ----------------------------------------------------------------------------
// box_distance_estimate_step_unit
// Signed distance to a shaped box, folded into a running minimum distance.
// ----------------------------------------------------------------------------
`default_nettype none

module box_distance_estimate_step_unit
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    // configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,

    // input beats
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // point_x, point_y, point_z, dist_in, deriv_in
    input  wire logic [183:0] s_axis_tdata,

    // output beats
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // moved_x, moved_y, moved_z, dist_out
    output logic [135:0]      m_axis_tdata,
    // got_closer
    output logic              m_axis_tuser
);
    import bdes_pkg::*;

    bdes_cfg_t  cfg_reg;
    bdes_side_t in_side;

    logic                ce;
    logic                fr_valid, sq_valid, dv_valid;
    bdes_side_t          fr_side, sq_side;
    logic [SQ_W-1:0]     fr_sumsq;
    logic [ROOT_W-1:0]   sq_len;
    bdes_res_t           dv_res;

    // output register plus one skid entry
    logic      out_valid_reg, skid_valid_reg;
    bdes_res_t out_reg, skid_reg;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x      <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.offset_z      <= '0;
            cfg_reg.half_size_x   <= ONE_FX;
            cfg_reg.half_size_y   <= ONE_FX;
            cfg_reg.half_size_z   <= ONE_FX;
            cfg_reg.curve_scale   <= '0;
            cfg_reg.pyramid_scale <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_OFFSET_X:      cfg_reg.offset_x      <= cfg_data;
                CFG_OFFSET_Y:      cfg_reg.offset_y      <= cfg_data;
                CFG_OFFSET_Z:      cfg_reg.offset_z      <= cfg_data;
                CFG_HALF_SIZE_X:   cfg_reg.half_size_x   <= cfg_data;
                CFG_HALF_SIZE_Y:   cfg_reg.half_size_y   <= cfg_data;
                CFG_HALF_SIZE_Z:   cfg_reg.half_size_z   <= cfg_data;
                CFG_CURVE_SCALE:   cfg_reg.curve_scale   <= cfg_data;
                CFG_PYRAMID_SCALE: cfg_reg.pyramid_scale <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // unpack the input beat
    // ------------------------------------------------------------------
    assign in_side.mx       = s_axis_tdata[31:0];
    assign in_side.my       = s_axis_tdata[63:32];
    assign in_side.mz       = s_axis_tdata[95:64];
    assign in_side.run_dist = s_axis_tdata[135:96];
    assign in_side.deriv    = s_axis_tdata[183:136];

    // whole pipeline moves whenever the skid entry is free
    assign ce            = !skid_valid_reg;
    assign s_axis_tready = ce;

    bdes_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_side   (in_side),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_sumsq (fr_sumsq)
    );

    bdes_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_rad    (fr_sumsq),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_len   (sq_len)
    );

    bdes_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_len    (sq_len),
        .out_valid (dv_valid),
        .out_res   (dv_res)
    );

    // ------------------------------------------------------------------
    // output register and skid entry
    // the last pipeline stage is drained whenever ce is high, so its beat
    // lands in the output register if that is free, else in the skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= dv_valid;
            end
        end
        else if (ce && dv_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : dv_res;
        end
        else if (ce && dv_valid)
        begin
            skid_reg <= dv_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.dist_out, out_reg.mz, out_reg.my, out_reg.mx};
    assign m_axis_tuser  = out_reg.got_closer;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // the skid entry only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid entry filled while output was free");

    // a taken output beat always frees the skid entry
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && m_axis_tready) |=> !skid_valid_reg)
        else $error("skid entry still valid after output beat taken");

    // a waiting skid beat moves to the output as soon as it is taken
    a_skid_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_axis_tready) |=> (out_valid_reg && out_reg == $past(skid_reg)))
        else $error("skid beat not forwarded to the output register");

endmodule

`default_nettype wire
